/* sv/ptpmp_pkg.sv */
`timescale 1ns / 1ps
// ptpmp_pkg: shared types and constants for the ptp message parser
// no dependencies; imported by every ptpmp module and the top level

package ptpmp_pkg;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_SHORT_VER  = 3'd1;
  localparam logic [2:0] ST_LEN_DOMAIN = 3'd2;
  localparam logic [2:0] ST_TYPE       = 3'd3;
  localparam logic [2:0] ST_BODY_SHORT = 3'd4;
  localparam logic [2:0] ST_BAD_TS     = 3'd5;

  localparam logic [3:0] KIND_SYNC       = 4'd0;
  localparam logic [3:0] KIND_DELAY_REQ  = 4'd1;
  localparam logic [3:0] KIND_FOLLOW_UP  = 4'd8;
  localparam logic [3:0] KIND_DELAY_RESP = 4'd9;
  localparam logic [3:0] KIND_ANNOUNCE   = 4'd11;

  localparam logic [3:0]  PTP_VERSION = 4'd2;
  localparam logic [15:0] HDR_BYTES   = 16'd34;
  localparam logic [15:0] TS_END      = 16'd44;
  localparam logic [15:0] DRESP_END   = 16'd54;
  localparam logic [15:0] ANN_END     = 16'd64;
  localparam logic [15:0] COUNT_MAX   = 16'hffff;

  localparam logic [29:0] NS_PER_S    = 30'd1000000000;
  localparam logic [31:0] NS_LIMIT    = 32'd1000000000;
  localparam logic [47:0] MAX_SECONDS = 48'd9223372036;
  localparam int          SEC_HALF    = 17;

  typedef struct packed {
    logic [3:0]  kind;
    logic [3:0]  version;
    logic [15:0] length;
    logic [7:0]  domain;
    logic        two_step;
    logic [63:0] correction;
    logic [63:0] src_clock;
    logic [15:0] src_port;
    logic [15:0] seq;
    logic [47:0] seconds;
    logic [31:0] nanos;
    logic [63:0] req_clock;
    logic [15:0] req_port;
    logic [15:0] total;
  } ptpmp_snap_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  kind;
    logic        two_step;
    logic [63:0] correction;
    logic [63:0] src_clock;
    logic [15:0] src_port;
    logic [15:0] seq;
    logic        timed;
    logic [46:0] pp_hi;
    logic [46:0] pp_lo;
    logic [29:0] nanos;
    logic        has_req;
    logic [63:0] req_clock;
    logic [15:0] req_port;
  } ptpmp_chk_t;

endpackage

/* sv/ptp_message_parser.sv */
`timescale 1ns / 1ps
// ptp_message_parser: top level of the PTPv2 message parser
// instantiates ptpmp_capture, ptpmp_check and ptpmp_assemble; uses ptpmp_pkg

// Takes a PTPv2 message one byte per clock while in_ready is high, with
// in_last_byte marking the final byte, and gives one result request per
// message through three registered stages: field snapshot; checks and the
// two seconds-times-1e9 partial products; timestamp sum into the result
// register. The stages collapse bubbles, so in_ready drops only when all of
// them hold results that the sink has not taken. Status codes: 0 ok, 1 short
// or bad version, 2 bad length or domain, 3 unsupported type, 4 body too
// short, 5 bad timestamp; on error every field except status and kind is
// zero. The user must write the domain register through the cfg port only
// while no message is open; the block does not enforce it.

module ptp_message_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_expected_domain,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_byte_value,
  input  logic               in_last_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_status,
  output logic [3:0]         out_message_kind,
  output logic               out_two_step,
  output logic signed [63:0] out_correction_field,
  output logic [63:0]        out_source_clock_id,
  output logic [15:0]        out_source_port_number,
  output logic [15:0]        out_sequence_id,
  output logic [63:0]        out_timestamp_ns,
  output logic [63:0]        out_requesting_clock_id,
  output logic [15:0]        out_requesting_port_number
);
  import ptpmp_pkg::*;

  logic [7:0]  expected_domain_r;
  logic        snap_valid, snap_go;
  ptpmp_snap_t snap;
  logic        chk_valid, chk_go;
  ptpmp_chk_t  chk;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_domain_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      expected_domain_r <= cfg_expected_domain;
    end
  end

  ptpmp_capture u_capture (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte_value (in_byte_value),
    .in_last_byte  (in_last_byte),
    .snap_go       (snap_go),
    .snap_valid    (snap_valid),
    .snap          (snap)
  );

  ptpmp_check u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .expected_domain (expected_domain_r),
    .snap_valid      (snap_valid),
    .snap            (snap),
    .snap_go         (snap_go),
    .chk_go          (chk_go),
    .chk_valid       (chk_valid),
    .chk             (chk)
  );

  ptpmp_assemble u_assemble (
    .clk                        (clk),
    .rst_n                      (rst_n),
    .chk_valid                  (chk_valid),
    .chk                        (chk),
    .chk_go                     (chk_go),
    .out_valid                  (out_valid),
    .out_ready                  (out_ready),
    .out_status                 (out_status),
    .out_message_kind           (out_message_kind),
    .out_two_step               (out_two_step),
    .out_correction_field       (out_correction_field),
    .out_source_clock_id        (out_source_clock_id),
    .out_source_port_number     (out_source_port_number),
    .out_sequence_id            (out_sequence_id),
    .out_timestamp_ns           (out_timestamp_ns),
    .out_requesting_clock_id    (out_requesting_clock_id),
    .out_requesting_port_number (out_requesting_port_number)
  );

endmodule

/* sv/ptpmp_capture.sv */
`timescale 1ns / 1ps
// ptpmp_capture: byte counter and header/body field capture
// snapshots the captured fields on the final byte; uses ptpmp_pkg

module ptpmp_capture (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_byte_value,
  input  logic                  in_last_byte,
  input  logic                  snap_go,
  output logic                  snap_valid,
  output ptpmp_pkg::ptpmp_snap_t snap
);
  import ptpmp_pkg::*;

  logic [15:0] count_r, count_nxt;
  ptpmp_snap_t cap_r, cap_nxt;
  ptpmp_snap_t snap_r;
  logic        snap_v_r;
  logic        accept;

  assign in_ready   = !snap_v_r || snap_go;
  assign accept     = in_valid && in_ready;
  assign snap_valid = snap_v_r;
  assign snap       = snap_r;

  always_comb begin
    cap_nxt   = cap_r;
    count_nxt = (count_r == COUNT_MAX) ? count_r : count_r + 16'd1;
    case (count_r) inside
      16'd0: cap_nxt.kind = in_byte_value[3:0];
      16'd1: cap_nxt.version = in_byte_value[3:0];
      [16'd2:16'd3]: cap_nxt.length = {cap_r.length[7:0], in_byte_value};
      16'd4: cap_nxt.domain = in_byte_value;
      16'd6: cap_nxt.two_step = in_byte_value[1];
      [16'd8:16'd15]: cap_nxt.correction = {cap_r.correction[55:0], in_byte_value};
      [16'd20:16'd27]: cap_nxt.src_clock = {cap_r.src_clock[55:0], in_byte_value};
      [16'd28:16'd29]: cap_nxt.src_port = {cap_r.src_port[7:0], in_byte_value};
      [16'd30:16'd31]: cap_nxt.seq = {cap_r.seq[7:0], in_byte_value};
      [16'd34:16'd39]: cap_nxt.seconds = {cap_r.seconds[39:0], in_byte_value};
      [16'd40:16'd43]: cap_nxt.nanos = {cap_r.nanos[23:0], in_byte_value};
      [16'd44:16'd51]: cap_nxt.req_clock = {cap_r.req_clock[55:0], in_byte_value};
      [16'd52:16'd53]: cap_nxt.req_port = {cap_r.req_port[7:0], in_byte_value};
      default: ;
    endcase
    cap_nxt.total = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      cap_r    <= '0;
      snap_v_r <= 1'b0;
    end else begin
      if (accept) begin
        if (in_last_byte) begin
          count_r <= '0;
          cap_r   <= '0;
        end else begin
          count_r <= count_nxt;
          cap_r   <= cap_nxt;
        end
      end
      if (accept && in_last_byte) begin
        snap_v_r <= 1'b1;
      end else if (snap_go) begin
        snap_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_last_byte) begin
      snap_r <= cap_nxt;
    end
  end

endmodule

/* sv/ptpmp_check.sv */
`timescale 1ns / 1ps
// ptpmp_check: message checks and seconds-to-nanoseconds partial products
// uses ptpmp_pkg; fed by ptpmp_capture

module ptpmp_check (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [7:0]             expected_domain,
  input  logic                   snap_valid,
  input  ptpmp_pkg::ptpmp_snap_t snap,
  output logic                   snap_go,
  input  logic                   chk_go,
  output logic                   chk_valid,
  output ptpmp_pkg::ptpmp_chk_t  chk
);
  import ptpmp_pkg::*;

  ptpmp_chk_t chk_r, chk_nxt;
  logic       chk_v_r;
  logic       timed, dresp, ann, ts_bad;

  assign snap_go   = !chk_v_r || chk_go;
  assign chk_valid = chk_v_r;
  assign chk       = chk_r;

  always_comb begin
    timed  = snap.kind inside {KIND_SYNC, KIND_DELAY_REQ, KIND_FOLLOW_UP, KIND_DELAY_RESP};
    dresp  = (snap.kind == KIND_DELAY_RESP);
    ann    = (snap.kind == KIND_ANNOUNCE);
    ts_bad = (snap.nanos >= NS_LIMIT) || (snap.seconds > MAX_SECONDS);

    chk_nxt            = '0;
    chk_nxt.kind       = snap.kind;
    chk_nxt.two_step   = snap.two_step;
    chk_nxt.correction = snap.correction;
    chk_nxt.src_clock  = snap.src_clock;
    chk_nxt.src_port   = snap.src_port;
    chk_nxt.seq        = snap.seq;
    chk_nxt.timed      = timed;
    chk_nxt.has_req    = dresp;
    chk_nxt.req_clock  = snap.req_clock;
    chk_nxt.req_port   = snap.req_port;
    chk_nxt.nanos      = snap.nanos[29:0];
    chk_nxt.pp_lo      = 47'(snap.seconds[SEC_HALF-1:0]) * 47'(NS_PER_S);
    chk_nxt.pp_hi      = 47'(snap.seconds[2*SEC_HALF-1:SEC_HALF]) * 47'(NS_PER_S);

    if (snap.total < HDR_BYTES || snap.version != PTP_VERSION) begin
      chk_nxt.status = ST_SHORT_VER;
    end else if (snap.length < HDR_BYTES || snap.length > snap.total ||
                 snap.domain != expected_domain) begin
      chk_nxt.status = ST_LEN_DOMAIN;
    end else if (!timed && !ann) begin
      chk_nxt.status = ST_TYPE;
    end else if (timed && snap.length < TS_END) begin
      chk_nxt.status = ST_BODY_SHORT;
    end else if (timed && ts_bad) begin
      chk_nxt.status = ST_BAD_TS;
    end else if (dresp && snap.length < DRESP_END) begin
      chk_nxt.status = ST_BODY_SHORT;
    end else if (ann && snap.length < ANN_END) begin
      chk_nxt.status = ST_BODY_SHORT;
    end else begin
      chk_nxt.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_v_r <= 1'b0;
    end else if (snap_go) begin
      chk_v_r <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_go && snap_valid) begin
      chk_r <= chk_nxt;
    end
  end

endmodule

/* sv/ptpmp_assemble.sv */
`timescale 1ns / 1ps
// ptpmp_assemble: timestamp sum, error masking and the result register
// uses ptpmp_pkg; fed by ptpmp_check

module ptpmp_assemble (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  chk_valid,
  input  ptpmp_pkg::ptpmp_chk_t chk,
  output logic                  chk_go,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            out_status,
  output logic [3:0]            out_message_kind,
  output logic                  out_two_step,
  output logic signed [63:0]    out_correction_field,
  output logic [63:0]           out_source_clock_id,
  output logic [15:0]           out_source_port_number,
  output logic [15:0]           out_sequence_id,
  output logic [63:0]           out_timestamp_ns,
  output logic [63:0]           out_requesting_clock_id,
  output logic [15:0]           out_requesting_port_number
);
  import ptpmp_pkg::*;

  logic        out_v_r;
  logic [2:0]  status_r;
  logic [3:0]  kind_r;
  logic        two_step_r, two_step_nxt;
  logic [63:0] correction_r, correction_nxt;
  logic [63:0] src_clock_r, src_clock_nxt;
  logic [15:0] src_port_r, src_port_nxt;
  logic [15:0] seq_r, seq_nxt;
  logic [63:0] ts_r, ts_nxt;
  logic [63:0] req_clock_r, req_clock_nxt;
  logic [15:0] req_port_r, req_port_nxt;
  logic        ok;

  assign chk_go = !out_v_r || out_ready;

  always_comb begin
    ok             = (chk.status == ST_OK);
    two_step_nxt   = ok && chk.two_step;
    correction_nxt = ok ? chk.correction : '0;
    src_clock_nxt  = ok ? chk.src_clock : '0;
    src_port_nxt   = ok ? chk.src_port : '0;
    seq_nxt        = ok ? chk.seq : '0;
    ts_nxt         = '0;
    if (ok && chk.timed) begin
      ts_nxt = {chk.pp_hi, {SEC_HALF{1'b0}}} + 64'(chk.pp_lo) + 64'(chk.nanos);
    end
    req_clock_nxt  = (ok && chk.has_req) ? chk.req_clock : '0;
    req_port_nxt   = (ok && chk.has_req) ? chk.req_port : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (chk_go) begin
      out_v_r <= chk_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chk_go && chk_valid) begin
      status_r     <= chk.status;
      kind_r       <= chk.kind;
      two_step_r   <= two_step_nxt;
      correction_r <= correction_nxt;
      src_clock_r  <= src_clock_nxt;
      src_port_r   <= src_port_nxt;
      seq_r        <= seq_nxt;
      ts_r         <= ts_nxt;
      req_clock_r  <= req_clock_nxt;
      req_port_r   <= req_port_nxt;
    end
  end

  assign out_valid                  = out_v_r;
  assign out_status                 = status_r;
  assign out_message_kind           = kind_r;
  assign out_two_step               = two_step_r;
  assign out_correction_field       = $signed(correction_r);
  assign out_source_clock_id        = src_clock_r;
  assign out_source_port_number     = src_port_r;
  assign out_sequence_id            = seq_r;
  assign out_timestamp_ns           = ts_r;
  assign out_requesting_clock_id    = req_clock_r;
  assign out_requesting_port_number = req_port_r;

endmodule

/* bench/ptp_result_monitor.sv */
`timescale 1ns / 1ps
// ptp_result_monitor: watches the cfg, byte and result channels of ptp_message_parser,
// predicts one parse result per message and compares it field by field
// uses ptpmp_pkg for status and message type codes

module ptp_result_monitor (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [7:0]         cfg_expected_domain,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [7:0]         in_byte_value,
  input  logic               in_last_byte,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [2:0]         out_status,
  input  logic [3:0]         out_message_kind,
  input  logic               out_two_step,
  input  logic signed [63:0] out_correction_field,
  input  logic [63:0]        out_source_clock_id,
  input  logic [15:0]        out_source_port_number,
  input  logic [15:0]        out_sequence_id,
  input  logic [63:0]        out_timestamp_ns,
  input  logic [63:0]        out_requesting_clock_id,
  input  logic [15:0]        out_requesting_port_number,
  output int                 fail_count,
  output int                 pending_count
);
  import ptpmp_pkg::*;

  localparam logic [15:0] MIN_HDR   = 16'd34;
  localparam logic [15:0] MIN_TS    = 16'd44;
  localparam logic [15:0] MIN_RESP  = 16'd54;
  localparam logic [15:0] MIN_ANN   = 16'd64;
  localparam logic [3:0]  V2        = 4'd2;
  localparam logic [31:0] NS_ROLL   = 32'd1000000000;
  localparam logic [47:0] SEC_CEIL  = 48'd9223372036;

  typedef struct packed {
    logic [2:0]         status;
    logic [3:0]         kind;
    logic               two_step;
    logic signed [63:0] correction;
    logic [63:0]        src_clock;
    logic [15:0]        src_port;
    logic [15:0]        seq;
    logic [63:0]        ts_ns;
    logic [63:0]        req_clock;
    logic [15:0]        req_port;
  } ptp_result_t;

  ptp_result_t parse_results_q[$];
  int          errs = 0;

  logic [7:0]  domain_r;
  logic [15:0] count_r;
  logic [3:0]  kind_r;
  logic [3:0]  ver_r;
  logic [15:0] len_r;
  logic [7:0]  dom_r;
  logic        flag_r;
  logic [63:0] corr_r;
  logic [63:0] sclk_r;
  logic [15:0] sport_r;
  logic [15:0] seq_r;
  logic [47:0] secs_r;
  logic [31:0] nanos_r;
  logic [63:0] rclk_r;
  logic [15:0] rport_r;

  task automatic clear_message();
    count_r = '0;
    kind_r  = '0;
    ver_r   = '0;
    len_r   = '0;
    dom_r   = '0;
    flag_r  = 1'b0;
    corr_r  = '0;
    sclk_r  = '0;
    sport_r = '0;
    seq_r   = '0;
    secs_r  = '0;
    nanos_r = '0;
    rclk_r  = '0;
    rport_r = '0;
  endtask

  function automatic ptp_result_t parse_verdict(input logic [15:0] total);
    ptp_result_t r;
    logic timed, dresp, ann;
    r = '0;
    r.kind = kind_r;
    timed = (kind_r == KIND_SYNC) || (kind_r == KIND_DELAY_REQ) ||
            (kind_r == KIND_FOLLOW_UP) || (kind_r == KIND_DELAY_RESP);
    dresp = kind_r == KIND_DELAY_RESP;
    ann = kind_r == KIND_ANNOUNCE;
    if (total < MIN_HDR || ver_r != V2) begin
      r.status = ST_SHORT_VER;
    end else if (len_r < MIN_HDR || len_r > total || dom_r != domain_r) begin
      r.status = ST_LEN_DOMAIN;
    end else if (!timed && !ann) begin
      r.status = ST_TYPE;
    end else if (timed && len_r < MIN_TS) begin
      r.status = ST_BODY_SHORT;
    end else if (timed && (nanos_r >= NS_ROLL || secs_r > SEC_CEIL)) begin
      r.status = ST_BAD_TS;
    end else if ((dresp && len_r < MIN_RESP) || (ann && len_r < MIN_ANN)) begin
      r.status = ST_BODY_SHORT;
    end else begin
      r.status     = ST_OK;
      r.two_step   = flag_r;
      r.correction = corr_r;
      r.src_clock  = sclk_r;
      r.src_port   = sport_r;
      r.seq        = seq_r;
      if (timed) r.ts_ns = 64'(secs_r) * 64'd1000000000 + 64'(nanos_r);
      if (dresp) begin
        r.req_clock = rclk_r;
        r.req_port  = rport_r;
      end
    end
    return r;
  endfunction

  task automatic take_byte(input logic [7:0] b, input logic last);
    logic [15:0] pos;
    pos = count_r;
    if (pos == 0) kind_r = b[3:0];
    else if (pos == 1) ver_r = b[3:0];
    else if (pos == 2 || pos == 3) len_r = {len_r[7:0], b};
    else if (pos == 4) dom_r = b;
    else if (pos == 6) flag_r = b[1];
    else if (pos >= 8 && pos <= 15) corr_r = {corr_r[55:0], b};
    else if (pos >= 20 && pos <= 27) sclk_r = {sclk_r[55:0], b};
    else if (pos == 28 || pos == 29) sport_r = {sport_r[7:0], b};
    else if (pos == 30 || pos == 31) seq_r = {seq_r[7:0], b};
    else if (pos >= 34 && pos <= 39) secs_r = {secs_r[39:0], b};
    else if (pos >= 40 && pos <= 43) nanos_r = {nanos_r[23:0], b};
    else if (pos >= 44 && pos <= 51) rclk_r = {rclk_r[55:0], b};
    else if (pos == 52 || pos == 53) rport_r = {rport_r[7:0], b};
    if (count_r != 16'hffff) count_r = count_r + 16'd1;
    if (last) begin
      parse_results_q.push_back(parse_verdict(count_r));
      clear_message();
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t mismatch %s: expected %0h actual %0h", $time, name, want, got);
      errs++;
    end
  endtask

  task automatic compare_result(input ptp_result_t want);
    check_field("status", 64'(want.status), 64'(out_status));
    check_field("message_kind", 64'(want.kind), 64'(out_message_kind));
    check_field("two_step", 64'(want.two_step), 64'(out_two_step));
    check_field("correction_field", want.correction, out_correction_field);
    check_field("source_clock_id", want.src_clock, out_source_clock_id);
    check_field("source_port_number", 64'(want.src_port), 64'(out_source_port_number));
    check_field("sequence_id", 64'(want.seq), 64'(out_sequence_id));
    check_field("timestamp_ns", want.ts_ns, out_timestamp_ns);
    check_field("requesting_clock_id", want.req_clock, out_requesting_clock_id);
    check_field("requesting_port_number", 64'(want.req_port),
                64'(out_requesting_port_number));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      domain_r = '0;
      clear_message();
      parse_results_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) domain_r = cfg_expected_domain;
      if (out_valid && out_ready) begin
        if (parse_results_q.size() == 0) begin
          $display("%0t unexpected result: expected none, actual status %0d kind %0d",
                   $time, out_status, out_message_kind);
          errs++;
        end else begin
          compare_result(parse_results_q.pop_front());
        end
      end
      if (in_valid && in_ready) take_byte(in_byte_value, in_last_byte);
    end
    pending_count <= parse_results_q.size();
    fail_count <= errs;
  end

endmodule

/* bench/tb_ptp_message_parser.sv */
`timescale 1ns / 1ps
// tb_ptp_message_parser: byte stimulus, domain writes and verdict for ptp_message_parser
// depends on ptpmp_pkg, ptp_message_parser and ptp_result_monitor

module tb_ptp_message_parser;
  import ptpmp_pkg::*;

  localparam int          STALL_LIMIT = 3000;
  localparam int          HOLD_CYCLES = 150;
  localparam logic [47:0] SEC_TOP     = 48'd9223372036;
  localparam logic [31:0] NS_TOP      = 32'd999999999;
  localparam logic [31:0] NS_WRAP     = 32'd1000000000;
  localparam logic [1:0]  FILL_RAND   = 2'd0;
  localparam logic [1:0]  FILL_ZERO   = 2'd1;
  localparam logic [1:0]  FILL_ONES   = 2'd2;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [7:0]         cfg_expected_domain;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         in_byte_value;
  logic               in_last_byte;
  logic               out_valid;
  logic               out_ready;
  logic [2:0]         out_status;
  logic [3:0]         out_message_kind;
  logic               out_two_step;
  logic signed [63:0] out_correction_field;
  logic [63:0]        out_source_clock_id;
  logic [15:0]        out_source_port_number;
  logic [15:0]        out_sequence_id;
  logic [63:0]        out_timestamp_ns;
  logic [63:0]        out_requesting_clock_id;
  logic [15:0]        out_requesting_port_number;

  int         fail_count;
  int         pending_count;
  int         idle_cycles = 0;
  int         bytes_sent = 0;
  logic       tx_idle;
  logic       rx_idle;
  logic       hold_phase;
  logic [7:0] cur_domain;
  logic [7:0] msg_q[$];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  ptp_message_parser uut (
    .clk                        (clk),
    .rst_n                      (rst_n),
    .cfg_valid                  (cfg_valid),
    .cfg_ready                  (cfg_ready),
    .cfg_expected_domain        (cfg_expected_domain),
    .in_valid                   (in_valid),
    .in_ready                   (in_ready),
    .in_byte_value              (in_byte_value),
    .in_last_byte               (in_last_byte),
    .out_valid                  (out_valid),
    .out_ready                  (out_ready),
    .out_status                 (out_status),
    .out_message_kind           (out_message_kind),
    .out_two_step               (out_two_step),
    .out_correction_field       (out_correction_field),
    .out_source_clock_id        (out_source_clock_id),
    .out_source_port_number     (out_source_port_number),
    .out_sequence_id            (out_sequence_id),
    .out_timestamp_ns           (out_timestamp_ns),
    .out_requesting_clock_id    (out_requesting_clock_id),
    .out_requesting_port_number (out_requesting_port_number)
  );

  ptp_result_monitor result_mon (
    .clk                        (clk),
    .rst_n                      (rst_n),
    .cfg_valid                  (cfg_valid),
    .cfg_ready                  (cfg_ready),
    .cfg_expected_domain        (cfg_expected_domain),
    .in_valid                   (in_valid),
    .in_ready                   (in_ready),
    .in_byte_value              (in_byte_value),
    .in_last_byte               (in_last_byte),
    .out_valid                  (out_valid),
    .out_ready                  (out_ready),
    .out_status                 (out_status),
    .out_message_kind           (out_message_kind),
    .out_two_step               (out_two_step),
    .out_correction_field       (out_correction_field),
    .out_source_clock_id        (out_source_clock_id),
    .out_source_port_number     (out_source_port_number),
    .out_sequence_id            (out_sequence_id),
    .out_timestamp_ns           (out_timestamp_ns),
    .out_requesting_clock_id    (out_requesting_clock_id),
    .out_requesting_port_number (out_requesting_port_number),
    .fail_count                 (fail_count),
    .pending_count              (pending_count)
  );

  // watchdog on cycles with no request moving on any channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("ptp_message_parser test failed");
        $finish;
      end
    end
  end

  // result sink
  initial begin
    int stall;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_phase) stall = HOLD_CYCLES;
      else if (rx_idle) stall = $urandom_range(0, 14);
      else stall = 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte_value <= b;
    in_last_byte <= last;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_message();
    int i;
    int gap;
    for (i = 0; i < msg_q.size(); i++) begin
      gap = tx_idle ? $urandom_range(0, 14) : 0;
      send_byte(msg_q[i], i == msg_q.size() - 1, gap);
    end
  endtask

  task automatic build_msg(input logic [3:0] kind, input logic [3:0] ver,
                           input logic [15:0] len_field, input logic [7:0] dom,
                           input logic [47:0] secs, input logic [31:0] nanos,
                           input int total, input logic [1:0] fill);
    int i;
    logic [7:0] b;
    msg_q.delete();
    for (i = 0; i < total; i++) begin
      if (fill == FILL_ZERO) b = 8'h00;
      else if (fill == FILL_ONES) b = 8'hff;
      else b = 8'($urandom);
      if (i == 0) b = {b[7:4], kind};
      else if (i == 1) b = {b[7:4], ver};
      else if (i == 2) b = len_field[15:8];
      else if (i == 3) b = len_field[7:0];
      else if (i == 4) b = dom;
      else if (i >= 34 && i <= 39) b = secs[8*(39-i) +: 8];
      else if (i >= 40 && i <= 43) b = nanos[8*(43-i) +: 8];
      msg_q.push_back(b);
    end
  endtask

  task automatic random_message();
    logic [3:0]  kind;
    logic [3:0]  ver;
    logic [15:0] len_field;
    logic [7:0]  dom;
    logic [47:0] secs;
    logic [31:0] nanos;
    int          total;
    int          floor_len;
    int          pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1:    kind = KIND_SYNC;
      2:       kind = KIND_DELAY_REQ;
      3:       kind = KIND_FOLLOW_UP;
      4, 5:    kind = KIND_DELAY_RESP;
      6, 7:    kind = KIND_ANNOUNCE;
      default: kind = 4'($urandom);
    endcase
    ver = ($urandom_range(0, 15) == 0) ? 4'($urandom) : PTP_VERSION;
    if (kind == KIND_DELAY_RESP) floor_len = 54;
    else if (kind == KIND_ANNOUNCE) floor_len = 64;
    else if (kind == KIND_SYNC || kind == KIND_DELAY_REQ || kind == KIND_FOLLOW_UP)
      floor_len = 44;
    else floor_len = 34;
    if ($urandom_range(0, 9) == 0) total = $urandom_range(1, 70);
    else total = floor_len + $urandom_range(0, 12);
    case ($urandom_range(0, 11))
      0:       len_field = 16'($urandom_range(34, total));
      1:       len_field = 16'(total + 1);
      2:       len_field = 16'($urandom);
      default: len_field = 16'(total);
    endcase
    dom = ($urandom_range(0, 15) == 0) ? 8'($urandom) : cur_domain;
    case ($urandom_range(0, 11))
      0:       secs = SEC_TOP;
      1:       secs = SEC_TOP + 48'd1;
      2:       secs = 48'({$urandom, $urandom});
      3:       secs = '0;
      default: secs = 48'({$urandom, $urandom} % (64'(SEC_TOP) + 64'd1));
    endcase
    case ($urandom_range(0, 11))
      0:       nanos = NS_TOP;
      1:       nanos = NS_WRAP;
      2:       nanos = $urandom;
      default: nanos = $urandom % NS_WRAP;
    endcase
    build_msg(kind, ver, len_field, dom, secs, nanos, total, FILL_RAND);
  endtask

  task automatic random_phase(input int byte_goal, input int msg_goal);
    int start_bytes;
    int sent;
    start_bytes = bytes_sent;
    sent = 0;
    while (bytes_sent - start_bytes < byte_goal || sent < msg_goal) begin
      random_message();
      send_message();
      sent++;
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending_count == 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_domain(input logic [7:0] d);
    cfg_valid <= 1'b1;
    cfg_expected_domain <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_domain = d;
  endtask

  initial begin
    int i;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_expected_domain = '0;
    in_valid = 1'b0;
    in_byte_value = '0;
    in_last_byte = 1'b0;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    hold_phase = 1'b0;
    cur_domain = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_domain(8'd0);

    // directed messages
    build_msg(KIND_SYNC, PTP_VERSION, 16'd44, 8'd0, '0, '0, 1, FILL_RAND);
    send_message();
    build_msg(KIND_SYNC, PTP_VERSION, 16'd33, 8'd0, '0, '0, 33, FILL_RAND);
    send_message();
    build_msg(KIND_SYNC, 4'd3, 16'd44, 8'd0, 48'd5, 32'd7, 44, FILL_RAND);
    send_message();
    build_msg(KIND_SYNC, PTP_VERSION, 16'd33, 8'd0, 48'd5, 32'd7, 44, FILL_RAND);
    send_message();
    build_msg(KIND_SYNC, PTP_VERSION, 16'd45, 8'd0, 48'd5, 32'd7, 44, FILL_RAND);
    send_message();
    build_msg(KIND_SYNC, PTP_VERSION, 16'd44, 8'd1, 48'd5, 32'd7, 44, FILL_RAND);
    send_message();
    build_msg(4'd2, PTP_VERSION, 16'd44, 8'd0, 48'd5, 32'd7, 44, FILL_RAND);
    send_message();
    build_msg(4'd15, PTP_VERSION, 16'd44, 8'd0, 48'd5, 32'd7, 44, FILL_RAND);
    send_message();
    build_msg(KIND_SYNC, PTP_VERSION, 16'd43, 8'd0, 48'd5, 32'd7, 44, FILL_RAND);
    send_message();
    build_msg(KIND_SYNC, PTP_VERSION, 16'd44, 8'd0, '0, '0, 44, FILL_ZERO);
    send_message();
    build_msg(KIND_DELAY_REQ, PTP_VERSION, 16'd44, 8'd0, SEC_TOP, NS_TOP, 50, FILL_ONES);
    send_message();
    build_msg(KIND_FOLLOW_UP, PTP_VERSION, 16'd44, 8'd0, 48'd9, NS_WRAP, 44, FILL_RAND);
    send_message();
    build_msg(KIND_SYNC, PTP_VERSION, 16'd44, 8'd0, SEC_TOP + 48'd1, '0, 44, FILL_RAND);
    send_message();
    build_msg(KIND_DELAY_REQ, PTP_VERSION, 16'd44, 8'd0, '1, '1, 44, FILL_ONES);
    send_message();
    build_msg(KIND_DELAY_RESP, PTP_VERSION, 16'd54, 8'd0, 48'd77, 32'd12345, 54,
              FILL_ONES);
    send_message();
    build_msg(KIND_DELAY_RESP, PTP_VERSION, 16'd53, 8'd0, 48'd77, 32'd1, 60, FILL_RAND);
    send_message();
    build_msg(KIND_DELAY_RESP, PTP_VERSION, 16'd50, 8'd0, 48'd77, NS_WRAP, 54, FILL_RAND);
    send_message();
    build_msg(KIND_ANNOUNCE, PTP_VERSION, 16'd64, 8'd0, '1, '1, 64, FILL_RAND);
    send_message();
    build_msg(KIND_ANNOUNCE, PTP_VERSION, 16'd63, 8'd0, 48'd3, 32'd3, 70, FILL_RAND);
    send_message();
    build_msg(KIND_ANNOUNCE, PTP_VERSION, 16'd64, 8'd0, 48'd3, 32'd3, 63, FILL_RAND);
    send_message();
    drain();

    write_domain(8'd255);
    random_phase(50, 1);
    drain();

    // sink holds off while short messages keep coming
    hold_phase <= 1'b1;
    for (i = 0; i < 10; i++) begin
      build_msg(4'($urandom), 4'($urandom), 16'($urandom), 8'($urandom), '0, '0,
                $urandom_range(1, 3), FILL_RAND);
      send_message();
    end
    hold_phase <= 1'b0;
    drain();

    write_domain(8'($urandom));
    random_phase(50, 1);
    drain();
    repeat (10) @(posedge clk);

    if (fail_count == 0) begin
      $display("ptp_message_parser test passed");
    end else begin
      $display("ptp_message_parser test failed");
    end
    $finish;
  end

endmodule

/* ptp_message_parser.f */
sv/ptpmp_pkg.sv
sv/ptpmp_capture.sv
sv/ptpmp_check.sv
sv/ptpmp_assemble.sv
sv/ptp_message_parser.sv
bench/ptp_result_monitor.sv
bench/tb_ptp_message_parser.sv
